// File: hw/rtl/lmd_pkg.sv
package lmd_pkg;

  // Field widths fixed by the item format.
  localparam int ID_W    = 10;  // node and community labels
  localparam int WGT_W   = 32;  // Q16.16 edge weight or node degree
  localparam int SUM_W   = 42;  // saturating sums and community degrees
  localparam int STAMP_W = 16;  // generation stamp of a link-weight sum
  localparam int RES_W   = 24;  // Q8.16 resolution
  localparam int INV_W   = 32;  // Q0.32 reciprocal of twice the total weight
  localparam int SCORE_W = 64;  // signed Q.16 score
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Default sizes.
  localparam int DEF_MAX_NODES    = 1024;
  localparam int DEF_MAX_NBR_COMM = 64;

  // Actions carried in the input user field.
  localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EDGE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FINISH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_2M     = 1'b1;

  localparam logic [RES_W-1:0]   RES_RESET = 24'h010000;
  localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

endpackage

// File: hw/rtl/louvain_local_move_decision.sv
// Louvain local-moving decision engine on Q16.16 weights. Each input transaction
// carries an action in s_tuser: load (a node with its degree, in its own
// community), begin move, neighbor edge, finish move, or read label. Finish and
// read give one output transaction each; the other actions give none. All
// per-node state lives in synchronous RAMs (community, degree, community degree,
// stamped link-weight sums) plus a small RAM holding neighbor communities in
// first-seen order. Items are processed one at a time; the output register lets
// a new item in while a result waits. Finish scores the old community and then
// each distinct neighbor community in turn; each score runs a byte-serial
// multiply chain, which sets the finish time. After reset, and on every
// begin move that wraps the 16-bit stamp, a clearing pass over all MAX_NODES
// entries resets the stamps, during which no input is taken; configuration
// writes are always accepted and must be issued only while the block is idle.
module louvain_local_move_decision import lmd_pkg::*; #(
  parameter int MAX_NODES        = DEF_MAX_NODES,
  parameter int MAX_NBR_COMM     = DEF_MAX_NBR_COMM
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,   // node_id, neighbor_id, edge_weight, zero fill
  input  logic [ACT_W-1:0]      s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // result_node, chosen_community, moved, zero fill
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int TAW  = (MAX_NBR_COMM > 1) ? $clog2(MAX_NBR_COMM) : 1;
  localparam int CW   = $clog2(MAX_NBR_COMM + 1);
  localparam int SMW  = STAMP_W + SUM_W;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_BEG_RD  = 4'd2;
  localparam logic [3:0] S_BEG_WR  = 4'd3;
  localparam logic [3:0] S_EDGE_C  = 4'd4;
  localparam logic [3:0] S_EDGE_W  = 4'd5;
  localparam logic [3:0] S_FIN_A   = 4'd6;
  localparam logic [3:0] S_FIN_OLD = 4'd7;
  localparam logic [3:0] S_FIN_OSC = 4'd8;
  localparam logic [3:0] S_FIN_TL  = 4'd9;
  localparam logic [3:0] S_FIN_DAT = 4'd10;
  localparam logic [3:0] S_FIN_SC  = 4'd11;
  localparam logic [3:0] S_FIN_UPD = 4'd12;
  localparam logic [3:0] S_FIN_ADD = 4'd13;
  localparam logic [3:0] S_READ    = 4'd14;
  localparam logic [3:0] S_RESULT  = 4'd15;

  logic [3:0]          state;
  logic [3:0]          state_next;

  // Configuration registers.
  logic [RES_W-1:0]    resolution;
  logic [INV_W-1:0]    inv_2m;

  // Move context.
  logic [ID_W-1:0]     moving_node;
  logic [STAMP_W-1:0]  cur_stamp;
  logic                clr_pending;
  logic [AW-1:0]       clr_addr;
  logic [CW-1:0]       touched_count;
  logic [CW-1:0]       k;
  logic [ID_W-1:0]     node_r;
  logic [WGT_W-1:0]    w_r;
  logic                rd_ok;
  logic [ID_W-1:0]     old_c;
  logic [ID_W-1:0]     cur_c;
  logic [ID_W-1:0]     best_c;
  logic [WGT_W-1:0]    deg_r;
  logic signed [SCORE_W-1:0] stay_score;
  logic signed [SCORE_W-1:0] lead_score;

  // Pending result.
  logic [ID_W-1:0]     res_node;
  logic [ID_W-1:0]     res_comm;
  logic                res_moved;

  // Incoming fields.
  logic                take;
  logic [ID_W-1:0]     in_node;
  logic [ID_W-1:0]     in_nb;
  logic [WGT_W-1:0]    in_w;
  logic                node_ok;
  logic                nb_ok;
  logic                edge_ok;

  // RAM ports.
  logic                comm_we;
  logic [AW-1:0]       comm_waddr;
  logic [ID_W-1:0]     comm_wdata;
  logic [AW-1:0]       comm_raddr;
  logic [ID_W-1:0]     comm_rdata;
  logic                deg_we;
  logic [AW-1:0]       deg_raddr;
  logic [WGT_W-1:0]    deg_rdata;
  logic                cdeg_we;
  logic [AW-1:0]       cdeg_waddr;
  logic [SUM_W-1:0]    cdeg_wdata;
  logic [AW-1:0]       cdeg_raddr;
  logic [SUM_W-1:0]    cdeg_rdata;
  logic                sum_we;
  logic [AW-1:0]       sum_waddr;
  logic [SMW-1:0]      sum_wdata;
  logic [AW-1:0]       sum_raddr;
  logic [SMW-1:0]      sum_rdata;
  logic                tl_we;
  logic [TAW-1:0]      tl_raddr;
  logic [ID_W-1:0]     tl_rdata;

  // Arithmetic.
  logic [STAMP_W-1:0]  sum_rd_stamp;
  logic [SUM_W-1:0]    sum_rd_val;
  logic                sum_hit;
  logic [SUM_W:0]      edge_add;
  logic [SUM_W:0]      cdeg_add;
  logic [SUM_W-1:0]    cdeg_sub;
  logic                sc_start;
  logic                sc_busy;
  logic                sc_done;
  logic signed [SCORE_W-1:0] sc_score;
  logic                better;
  logic [CW-1:0]       k_inc;

  assign in_node = s_tdata[9:0];
  assign in_nb   = s_tdata[19:10];
  assign in_w    = s_tdata[51:20];
  assign take    = s_tvalid && s_tready;
  assign node_ok = 32'(in_node) < 32'(MAX_NODES);
  assign nb_ok   = 32'(in_nb) < 32'(MAX_NODES);
  assign edge_ok = (cur_stamp != '0) && nb_ok && (in_nb != moving_node);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign sum_rd_stamp = sum_rdata[SMW-1:SUM_W];
  assign sum_rd_val   = sum_rdata[SUM_W-1:0];
  // A sum counts only if it was written under the open move's stamp.
  assign sum_hit  = (cur_stamp != '0) && (sum_rd_stamp == cur_stamp);
  assign edge_add = {1'b0, sum_rd_val} + (SUM_W + 1)'(w_r);
  assign cdeg_add = {1'b0, cdeg_rdata} + (SUM_W + 1)'(deg_r);
  assign cdeg_sub = (cdeg_rdata >= SUM_W'(deg_r)) ? cdeg_rdata - SUM_W'(deg_r) : '0;
  assign k_inc    = k + CW'(1);

  // A candidate wins on a strictly higher score, or on a tie with the best
  // when it beats the old community and carries a lower label.
  assign better = (sc_score > lead_score) ||
                  ((sc_score == lead_score) && (sc_score > stay_score) && (cur_c < best_c));

  always_comb begin
    state_next = state;
    comm_we    = 1'b0;
    comm_waddr = AW'(in_node);
    comm_wdata = in_node;
    comm_raddr = AW'(in_node);
    deg_we     = 1'b0;
    deg_raddr  = AW'(in_node);
    cdeg_we    = 1'b0;
    cdeg_waddr = AW'(in_node);
    cdeg_wdata = SUM_W'(in_w);
    cdeg_raddr = AW'(old_c);
    sum_we     = 1'b0;
    sum_waddr  = clr_addr;
    sum_wdata  = '0;
    sum_raddr  = AW'(old_c);
    tl_we      = 1'b0;
    tl_raddr   = '0;
    sc_start   = 1'b0;
    case (state)
      S_CLEAR: begin
        sum_we = 1'b1;
        if (clr_addr == AW'(MAX_NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          case (s_tuser)
            ACT_LOAD: begin
              comm_we = node_ok;
              deg_we  = node_ok;
              cdeg_we = node_ok;
            end
            ACT_BEGIN: begin
              if (node_ok) begin
                state_next = S_BEG_RD;
              end
            end
            ACT_EDGE: begin
              comm_raddr = AW'(in_nb);
              if (edge_ok) begin
                state_next = S_EDGE_C;
              end
            end
            ACT_FINISH: begin
              comm_raddr = AW'(moving_node);
              deg_raddr  = AW'(moving_node);
              state_next = S_FIN_A;
            end
            ACT_READ: begin
              state_next = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_BEG_RD: begin
        cdeg_raddr = AW'(comm_rdata);
        state_next = S_BEG_WR;
      end
      S_BEG_WR: begin
        cdeg_we    = 1'b1;
        cdeg_waddr = AW'(old_c);
        cdeg_wdata = cdeg_sub;
        state_next = clr_pending ? S_CLEAR : S_IDLE;
      end
      S_EDGE_C: begin
        sum_raddr  = AW'(comm_rdata);
        state_next = S_EDGE_W;
      end
      S_EDGE_W: begin
        sum_waddr = AW'(cur_c);
        if (sum_hit) begin
          sum_we    = 1'b1;
          sum_wdata = {cur_stamp, edge_add[SUM_W] ? {SUM_W{1'b1}} : edge_add[SUM_W-1:0]};
        end else if (touched_count < CW'(MAX_NBR_COMM)) begin
          sum_we    = 1'b1;
          sum_wdata = {cur_stamp, SUM_W'(w_r)};
          tl_we     = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_FIN_A: begin
        sum_raddr  = AW'(comm_rdata);
        cdeg_raddr = AW'(comm_rdata);
        state_next = S_FIN_OLD;
      end
      S_FIN_OLD, S_FIN_DAT: begin
        sc_start   = 1'b1;
        state_next = (state == S_FIN_OLD) ? S_FIN_OSC : S_FIN_SC;
      end
      S_FIN_OSC: begin
        tl_raddr = '0;
        if (sc_done) begin
          state_next = (touched_count == '0) ? S_FIN_UPD : S_FIN_TL;
        end
      end
      S_FIN_TL: begin
        sum_raddr  = AW'(tl_rdata);
        cdeg_raddr = AW'(tl_rdata);
        state_next = S_FIN_DAT;
      end
      S_FIN_SC: begin
        tl_raddr = k_inc[TAW-1:0];
        if (sc_done) begin
          state_next = (k_inc == touched_count) ? S_FIN_UPD : S_FIN_TL;
        end
      end
      S_FIN_UPD: begin
        comm_we    = 1'b1;
        comm_waddr = AW'(moving_node);
        comm_wdata = best_c;
        cdeg_raddr = AW'(best_c);
        state_next = S_FIN_ADD;
      end
      S_FIN_ADD: begin
        cdeg_we    = 1'b1;
        cdeg_waddr = AW'(best_c);
        cdeg_wdata = cdeg_add[SUM_W] ? {SUM_W{1'b1}} : cdeg_add[SUM_W-1:0];
        state_next = S_RESULT;
      end
      S_READ: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      resolution    <= RES_RESET;
      inv_2m        <= '0;
      moving_node   <= '0;
      cur_stamp     <= '0;
      clr_pending   <= 1'b0;
      clr_addr      <= '0;
      touched_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RESOLUTION: resolution <= cfg_data[RES_W-1:0];
          CFG_INV_2M:     inv_2m     <= cfg_data;
          default:        resolution <= resolution;
        endcase
      end
      if (state == S_CLEAR) begin
        clr_addr    <= (state_next == S_IDLE) ? '0 : clr_addr + AW'(1);
        clr_pending <= 1'b0;
      end
      // A begin move opens a new stamp generation; the wrap forces a clearing pass.
      if (take && (s_tuser == ACT_BEGIN) && node_ok) begin
        moving_node   <= in_node;
        touched_count <= '0;
        if (cur_stamp == STAMP_MAX) begin
          cur_stamp   <= STAMP_W'(1);
          clr_pending <= 1'b1;
        end else begin
          cur_stamp <= cur_stamp + STAMP_W'(1);
        end
      end
      if ((state == S_EDGE_W) && !sum_hit && (touched_count < CW'(MAX_NBR_COMM))) begin
        touched_count <= touched_count + CW'(1);
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_RESULT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (take) begin
      node_r <= in_node;
      w_r    <= in_w;
      rd_ok  <= node_ok;
    end
    case (state)
      S_BEG_RD: begin
        old_c <= comm_rdata;
        deg_r <= deg_rdata;
      end
      S_EDGE_C: begin
        cur_c <= comm_rdata;
      end
      S_FIN_A: begin
        old_c <= comm_rdata;
        deg_r <= deg_rdata;
      end
      S_FIN_OSC: begin
        if (sc_done) begin
          stay_score <= sc_score;
          lead_score <= sc_score;
          best_c     <= old_c;
          k          <= '0;
        end
      end
      S_FIN_TL: begin
        cur_c <= tl_rdata;
      end
      S_FIN_SC: begin
        if (sc_done) begin
          k <= k_inc;
          if (better) begin
            lead_score <= sc_score;
            best_c     <= cur_c;
          end
        end
      end
      S_FIN_ADD: begin
        res_node  <= moving_node;
        res_comm  <= best_c;
        res_moved <= (best_c != old_c);
      end
      S_READ: begin
        res_node  <= node_r;
        res_comm  <= rd_ok ? comm_rdata : '0;
        res_moved <= 1'b0;
      end
      default: begin
        k <= k;
      end
    endcase
    if ((state == S_RESULT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, res_moved, res_comm, res_node};
    end
  end

  lmd_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_comm_ram (
    .clk(clk), .we(comm_we), .waddr(comm_waddr), .wdata(comm_wdata),
    .raddr(comm_raddr), .rdata(comm_rdata)
  );

  lmd_ram #(.WIDTH(WGT_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(AW'(in_node)), .wdata(in_w),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  lmd_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NODES)) u_cdeg_ram (
    .clk(clk), .we(cdeg_we), .waddr(cdeg_waddr), .wdata(cdeg_wdata),
    .raddr(cdeg_raddr), .rdata(cdeg_rdata)
  );

  lmd_ram #(.WIDTH(SMW), .DEPTH(MAX_NODES)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  lmd_ram #(.WIDTH(ID_W), .DEPTH(MAX_NBR_COMM)) u_touched_ram (
    .clk(clk), .we(tl_we), .waddr(touched_count[TAW-1:0]), .wdata(cur_c),
    .raddr(tl_raddr), .rdata(tl_rdata)
  );

  lmd_score u_score (
    .clk(clk), .rst(rst), .start(sc_start),
    .res(resolution), .deg(deg_r),
    .cdeg(cdeg_rdata), .inv(inv_2m),
    .weight(sum_hit ? sum_rd_val : '0),
    .busy(sc_busy), .done(sc_done), .score(sc_score)
  );

  a_touched_bound: assert property (@(posedge clk) disable iff (rst)
    touched_count <= CW'(MAX_NBR_COMM))
    else $error("neighbor community count beyond capacity");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input taken during stamp clearing pass");

  a_score_idle_start: assert property (@(posedge clk) disable iff (rst)
    sc_start |-> !sc_busy)
    else $error("score unit started while busy");

  a_begin_empties: assert property (@(posedge clk) disable iff (rst)
    (take && (s_tuser == ACT_BEGIN) && node_ok) |=> (touched_count == '0))
    else $error("begin move did not empty the neighbor list");

endmodule

// File: hw/rtl/lmd_ram.sv
module lmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lmd_score.sv
module lmd_score import lmd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [RES_W-1:0]          res,
  input  logic [WGT_W-1:0]          deg,
  input  logic [SUM_W-1:0]          cdeg,
  input  logic [INV_W-1:0]          inv,
  input  logic [SUM_W-1:0]          weight,
  output logic                      busy,
  output logic                      done,
  output logic signed [SCORE_W-1:0] score
);

  // Penalty res*deg*cdeg*inv is formed in three chained products, each
  // one byte of the multiplier per cycle, most significant byte first.
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_M1   = 3'd1;
  localparam logic [2:0] P_M2   = 3'd2;
  localparam logic [2:0] P_M3   = 3'd3;
  localparam logic [2:0] P_DONE = 3'd4;

  logic [2:0]       phase;
  logic [97:0]      a_reg;
  logic [47:0]      b_reg;
  logic [2:0]       cnt;
  logic [129:0]     acc;
  logic [129:0]     acc_next;
  logic [105:0]     prod;
  logic [SUM_W-1:0] cdeg_l;
  logic [INV_W-1:0] inv_l;
  logic [SUM_W-1:0] weight_l;
  logic [62:0]      pen;

  assign prod     = 106'(a_reg) * 106'(b_reg[47:40]);
  assign acc_next = {acc[121:0], 8'h00} + 130'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE: begin
          if (start) begin
            a_reg    <= 98'(deg);
            b_reg    <= {res, 24'h000000};
            cnt      <= 3'd3;
            acc      <= '0;
            cdeg_l   <= cdeg;
            inv_l    <= inv;
            weight_l <= weight;
            phase    <= P_M1;
          end
        end
        P_M1, P_M2, P_M3: begin
          acc   <= acc_next;
          b_reg <= {b_reg[39:0], 8'h00};
          cnt   <= cnt - 3'd1;
          if (cnt == 3'd1) begin
            case (phase)
              P_M1: begin
                a_reg <= acc_next[97:0];
                b_reg <= {6'b000000, cdeg_l};
                cnt   <= 3'd6;
                acc   <= '0;
                phase <= P_M2;
              end
              P_M2: begin
                a_reg <= acc_next[97:0];
                b_reg <= {inv_l, 16'h0000};
                cnt   <= 3'd4;
                acc   <= '0;
                phase <= P_M3;
              end
              default: begin
                phase <= P_DONE;
              end
            endcase
          end
        end
        P_DONE: begin
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  // The penalty is the product over 2^64, saturated at 2^62.
  assign pen   = (|acc[129:126]) ? {1'b1, 62'h0} : {1'b0, acc[125:64]};
  assign score = $signed({22'h0, weight_l}) - $signed({1'b0, pen});
  assign busy  = (phase != P_IDLE);
  assign done  = (phase == P_DONE);

endmodule
